// ===== rtl/rhc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Widths, beat types and the payload carried down the divider pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CompBits  = 8;
  localparam int FracBits  = 16;
  // Six times the largest possible delta fits in this width.
  localparam int DivBits   = CompBits + 3;
  localparam int DivStages = FracBits;

  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FracBits-1:0] hue;
    logic [FracBits-1:0] saturation;
    logic [CompBits-1:0] value;
  } result_t;

  // Partial state of both long divisions, one quotient bit per stage.
  typedef struct packed {
    logic [DivBits-1:0]  hue_rem;
    logic [DivBits-1:0]  hue_div;
    logic [FracBits-1:0] hue_q;
    logic [CompBits-1:0] sat_rem;
    logic [CompBits-1:0] sat_div;
    logic [FracBits-1:0] sat_low;
    logic [FracBits-1:0] sat_q;
    logic [CompBits-1:0] value;
    logic                gray;
  } div_t;

endpackage
`default_nettype wire

// ===== rtl/rhc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two register stages: max and min of the pixel, then delta, hue numerator,
// hue divisor and saturation dividend.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic            clk,
  input  logic            en,
  input  rhc_pkg::pixel_t pixel,
  output rhc_pkg::div_t   div_init
);
  import rhc_pkg::*;

  logic [CompBits-1:0] mx_c;
  logic [CompBits-1:0] mn_c;
  pixel_t              pix;
  logic [CompBits-1:0] mx;
  logic [CompBits-1:0] mn;

  logic [CompBits-1:0]          delta;
  logic [DivBits-1:0]           div6;
  logic signed [DivBits:0]      d_s;
  logic signed [DivBits:0]      r_s;
  logic signed [DivBits:0]      g_s;
  logic signed [DivBits:0]      b_s;
  logic signed [DivBits:0]      num_raw;
  logic [CompBits+FracBits-1:0] sat_num;
  div_t                         init_c;

  always_comb begin
    mx_c = pixel.red;
    if (pixel.green > mx_c) mx_c = pixel.green;
    if (pixel.blue > mx_c) mx_c = pixel.blue;
    mn_c = pixel.red;
    if (pixel.green < mn_c) mn_c = pixel.green;
    if (pixel.blue < mn_c) mn_c = pixel.blue;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix <= pixel;
      mx  <= mx_c;
      mn  <= mn_c;
    end
  end

  always_comb begin
    delta = mx - mn;
    div6  = (DivBits'(delta) << 2) + (DivBits'(delta) << 1);
    d_s   = $signed((DivBits+1)'(delta));
    r_s   = $signed((DivBits+1)'(pix.red));
    g_s   = $signed((DivBits+1)'(pix.green));
    b_s   = $signed((DivBits+1)'(pix.blue));
    // Red wins ties, then green.
    if (pix.red == mx) begin
      num_raw = g_s - b_s;
    end else if (pix.green == mx) begin
      num_raw = (d_s <<< 1) + b_s - r_s;
    end else begin
      num_raw = (d_s <<< 2) + r_s - g_s;
    end
    if (num_raw < 0) num_raw = num_raw + $signed({1'b0, div6});
    // delta times all ones of the fraction, as a shift and a subtract.
    sat_num = {delta, {FracBits{1'b0}}} - (CompBits+FracBits)'(delta);

    init_c.hue_rem = num_raw[DivBits-1:0];
    init_c.hue_div = div6;
    init_c.hue_q   = '0;
    init_c.sat_rem = sat_num[CompBits+FracBits-1:FracBits];
    init_c.sat_div = mx;
    init_c.sat_low = sat_num[FracBits-1:0];
    init_c.sat_q   = '0;
    init_c.value   = mx;
    init_c.gray    = (delta == '0);
  end

  always_ff @(posedge clk) begin
    if (en) div_init <= init_c;
  end

endmodule
`default_nettype wire

// ===== rtl/rhc_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV divider stage
// One restoring step of both the hue and the saturation division, registered.
// ----------------------------------------------------------------------------
module rhc_div_stage (
  input  logic          clk,
  input  logic          en,
  input  rhc_pkg::div_t cur,
  output rhc_pkg::div_t nxt
);
  import rhc_pkg::*;

  logic [DivBits:0]  h_try;
  logic [DivBits:0]  h_diff;
  logic [CompBits:0] s_try;
  logic [CompBits:0] s_diff;
  div_t              step;

  always_comb begin
    step   = cur;
    // The hue dividend is the numerator followed by zeros.
    h_try  = {cur.hue_rem, 1'b0};
    h_diff = h_try - {1'b0, cur.hue_div};
    if (h_try >= {1'b0, cur.hue_div}) begin
      step.hue_rem = h_diff[DivBits-1:0];
      step.hue_q   = {cur.hue_q[FracBits-2:0], 1'b1};
    end else begin
      step.hue_rem = h_try[DivBits-1:0];
      step.hue_q   = {cur.hue_q[FracBits-2:0], 1'b0};
    end

    s_try  = {cur.sat_rem, cur.sat_low[FracBits-1]};
    s_diff = s_try - {1'b0, cur.sat_div};
    step.sat_low = {cur.sat_low[FracBits-2:0], 1'b0};
    if (s_try >= {1'b0, cur.sat_div}) begin
      step.sat_rem = s_diff[CompBits-1:0];
      step.sat_q   = {cur.sat_q[FracBits-2:0], 1'b1};
    end else begin
      step.sat_rem = s_try[CompBits-1:0];
      step.sat_q   = {cur.sat_q[FracBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) nxt <= step;
  end

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsv_converter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Pixel stream conversion from red, green, blue to hue, saturation, value.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while pixel_stall is low and delivers one
// result per pixel, in order. A pixel passes through two front-end stages
// (max/min, then delta and the hue numerator), sixteen divider stages that
// each resolve one quotient bit of both the hue and the saturation
// division, and the output register. A one-beat skid register behind the
// output lets the pipeline keep taking pixels while a result waits; once
// it fills, the pipeline freezes and pixel_stall rises. Gray pixels, black
// included, give hue and saturation of zero.
module rgb_to_hsv_converter_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  rhc_pkg::pixel_t  pixel,
  output logic             result_valid,
  input  logic             result_stall,
  output rhc_pkg::result_t result
);
  import rhc_pkg::*;

  localparam int PipeStages = DivStages + 2;

  logic                  en;
  logic [PipeStages-1:0] vld;
  div_t                  dv [0:DivStages];
  result_t               fin;
  result_t               skid;
  logic                  skid_vld;
  logic                  last_vld;

  assign en          = !skid_vld;
  assign pixel_stall = skid_vld;
  assign last_vld    = vld[PipeStages-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PipeStages-2:0], pixel_valid};
    end
  end

  rhc_front u_front (
    .clk      (clk),
    .en       (en),
    .pixel    (pixel),
    .div_init (dv[0])
  );

  for (genvar i = 0; i < DivStages; i++) begin : g_div
    rhc_div_stage u_stage (
      .clk (clk),
      .en  (en),
      .cur (dv[i]),
      .nxt (dv[i+1])
    );
  end

  always_comb begin
    fin.hue        = dv[DivStages].gray ? '0 : dv[DivStages].hue_q;
    fin.saturation = dv[DivStages].gray ? '0 : dv[DivStages].sat_q;
    fin.value      = dv[DivStages].value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_vld     <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_vld) begin
        result_valid <= 1'b1;
        skid_vld     <= 1'b0;
      end else begin
        result_valid <= last_vld;
      end
    end else if (last_vld) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result <= skid_vld ? skid : fin;
    end else if (last_vld) begin
      skid <= fin;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> result_valid)
    else $error("skid register holds a beat while the output is empty");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_stall) |-> $past(result_valid && result_stall))
    else $error("pixel stall rose without a stalled result");

  a_black_is_gray: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.value == '0) |->
      (result.saturation == '0 && result.hue == '0))
    else $error("black pixel gave nonzero hue or saturation");

  a_unsaturated_hue: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturation == '0) |-> (result.hue == '0))
    else $error("unsaturated pixel gave nonzero hue");
`endif

endmodule
`default_nettype wire

// ===== test/rgb_to_hsv_converter_top_tb.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Sends pixel beats and checks every result beat against a predictor that
// works out hue, saturation and value in plain integer arithmetic. The run
// covers directed corner pixels and a random stream under varying idling.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  localparam int PipeLatency = 19;
  localparam int SatScale    = (1 << FracBits) - 1;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    pixel_valid  = 1'b0;
  logic    pixel_stall;
  pixel_t  pixel        = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  result_t     expected_hsv[$];
  result_t     want;

  rgb_to_hsv_converter_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hue, saturation and value of one pixel, computed with exact integers.
  function automatic result_t hsv_of(pixel_t p);
    result_t     res;
    int unsigned r, g, b, hi, lo, delta;
    longint      num;
    r = p.red;
    g = p.green;
    b = p.blue;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    res.value = CompBits'(hi);
    res.saturation = (hi == 0) ? '0 : FracBits'((delta * SatScale) / hi);
    res.hue = '0;
    if (delta != 0) begin
      // Red wins a tie for the largest component, then green.
      if (r == hi)
        num = longint'(g) - longint'(b);
      else if (g == hi)
        num = 2 * longint'(delta) + longint'(b) - longint'(r);
      else
        num = 4 * longint'(delta) + longint'(r) - longint'(g);
      if (num < 0) num += 6 * longint'(delta);
      res.hue = FracBits'((num << FracBits) / (6 * longint'(delta)));
    end
    return res;
  endfunction

  // Offers one pixel beat and returns at the edge that accepts it. Valid is
  // left high so that back-to-back beats need no second assignment.
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    expected_hsv.push_back(hsv_of(p));
  endtask

  function automatic pixel_t make_pixel(int unsigned r, int unsigned g, int unsigned b);
    pixel_t p;
    p.red   = CompBits'(r);
    p.green = CompBits'(g);
    p.blue  = CompBits'(b);
    return p;
  endfunction

  task automatic test_gray_pixels();
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(255, 255, 255));
    send_pixel(make_pixel(128, 128, 128));
    send_pixel(make_pixel(1, 1, 1));
  endtask

  task automatic test_primary_hues();
    send_pixel(make_pixel(255, 0, 0));
    send_pixel(make_pixel(0, 255, 0));
    send_pixel(make_pixel(0, 0, 255));
    send_pixel(make_pixel(1, 0, 0));
    send_pixel(make_pixel(0, 0, 1));
  endtask

  // Ties for the largest component pick the sector in red, green, blue order.
  task automatic test_max_ties();
    send_pixel(make_pixel(255, 255, 0));
    send_pixel(make_pixel(0, 255, 255));
    send_pixel(make_pixel(255, 0, 255));
    send_pixel(make_pixel(1, 1, 0));
    send_pixel(make_pixel(0, 1, 1));
  endtask

  // Red largest with blue above green wraps around to just below a full turn.
  task automatic test_hue_wrap();
    send_pixel(make_pixel(255, 0, 1));
    send_pixel(make_pixel(255, 254, 255));
    send_pixel(make_pixel(255, 254, 254));
    send_pixel(make_pixel(200, 10, 255));
    send_pixel(make_pixel(10, 255, 200));
    send_pixel(make_pixel(255, 200, 10));
  endtask

  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned base;
    p.red   = CompBits'($urandom);
    p.green = CompBits'($urandom);
    p.blue  = CompBits'($urandom);
    case ($urandom_range(3))
      0: begin
        // Nearly gray: small deltas stress the hue division.
        base    = $urandom_range(252);
        p.red   = CompBits'(base + $urandom_range(3));
        p.green = CompBits'(base + $urandom_range(3));
        p.blue  = CompBits'(base + $urandom_range(3));
      end
      1: begin
        case ($urandom_range(2))
          0: p.green = p.red;
          1: p.blue  = p.green;
          default: p.red = p.blue;
        endcase
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_random_pixels(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_hsv.size() == 0) begin
        $error("result beat with nothing expected: hue %0d saturation %0d value %0d",
               result.hue, result.saturation, result.value);
        mismatches++;
      end else begin
        want = expected_hsv.pop_front();
        if (result.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, result.hue);
          mismatches++;
        end
        if (result.saturation !== want.saturation) begin
          $error("saturation: expected %0d, got %0d", want.saturation, result.saturation);
          mismatches++;
        end
        if (result.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, result.value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct  = 25;
    recv_stall_pct = 60;
    test_gray_pixels();
    test_primary_hues();
    test_max_ties();
    test_hue_wrap();
    test_random_pixels(330);

    send_idle_pct  = 60;
    recv_stall_pct = 25;
    test_random_pixels(330);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_pixels(330);
    pixel_valid <= 1'b0;

    while (expected_hsv.size() != 0) @(posedge clk);
    repeat (PipeLatency + 6) @(posedge clk);

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
